FILE: sv/vmix_pkg.sv
package vmix_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIX_MODE      = 3'd0;
    localparam logic [2:0] CFG_PITCH_STEP    = 3'd1;
    localparam logic [2:0] CFG_VOLUME_LEFT   = 3'd2;
    localparam logic [2:0] CFG_VOLUME_RIGHT  = 3'd3;
    localparam logic [2:0] CFG_COEF_INPUT    = 3'd4;
    localparam logic [2:0] CFG_COEF_HIST_ONE = 3'd5;
    localparam logic [2:0] CFG_COEF_HIST_TWO = 3'd6;

    // Kinds of mixing selected by mix_mode bits 2:1
    localparam logic [1:0] KIND_PLAIN    = 2'd0;
    localparam logic [1:0] KIND_INTERP   = 2'd1;
    localparam logic [1:0] KIND_RAMPED   = 2'd2;
    localparam logic [1:0] KIND_FILTERED = 2'd3;

    // Clamp limits of the filter output
    localparam int FILT_OUT_MIN = -32768;
    localparam int FILT_OUT_MAX = 32767;

    // Saturation of the advance count
    localparam logic [8:0] ADVANCE_MAX = 9'd511;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INT0,
        ST_INT1,
        ST_FIL0,
        ST_FIL1,
        ST_FIL2,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INT0,
        OP_INT1,
        OP_FIL0,
        OP_FIL1,
        OP_FIL2,
        OP_GAIN_L,
        OP_GAIN_R,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
    } status_t;

endpackage

FILE: sv/vmix_ctrl.sv
module vmix_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  vmix_pkg::status_t status,
    output vmix_pkg::cmd_t    cmd
);

    vmix_pkg::state_t state_reg;
    vmix_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             out_free;

    assign in_stall  = (state_reg != vmix_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vmix_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.kind == vmix_pkg::KIND_PLAIN)
                    begin
                        state_next = vmix_pkg::ST_GAIN_L;
                    end
                    else
                    begin
                        state_next = vmix_pkg::ST_INT0;
                    end
                end
            end
            vmix_pkg::ST_INT0:
            begin
                state_next = vmix_pkg::ST_INT1;
            end
            vmix_pkg::ST_INT1:
            begin
                if (status.kind == vmix_pkg::KIND_FILTERED)
                begin
                    state_next = vmix_pkg::ST_FIL0;
                end
                else
                begin
                    state_next = vmix_pkg::ST_GAIN_L;
                end
            end
            vmix_pkg::ST_FIL0:   state_next = vmix_pkg::ST_FIL1;
            vmix_pkg::ST_FIL1:   state_next = vmix_pkg::ST_FIL2;
            vmix_pkg::ST_FIL2:   state_next = vmix_pkg::ST_GAIN_L;
            vmix_pkg::ST_GAIN_L: state_next = vmix_pkg::ST_GAIN_R;
            vmix_pkg::ST_GAIN_R: state_next = vmix_pkg::ST_FINISH;
            vmix_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = vmix_pkg::ST_IDLE;
                end
            end
            default: state_next = vmix_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd.op = vmix_pkg::OP_NONE;
        case (state_reg)
            vmix_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.op = vmix_pkg::OP_LOAD;
                end
            end
            vmix_pkg::ST_INT0:   cmd.op = vmix_pkg::OP_INT0;
            vmix_pkg::ST_INT1:   cmd.op = vmix_pkg::OP_INT1;
            vmix_pkg::ST_FIL0:   cmd.op = vmix_pkg::OP_FIL0;
            vmix_pkg::ST_FIL1:   cmd.op = vmix_pkg::OP_FIL1;
            vmix_pkg::ST_FIL2:   cmd.op = vmix_pkg::OP_FIL2;
            vmix_pkg::ST_GAIN_L: cmd.op = vmix_pkg::OP_GAIN_L;
            vmix_pkg::ST_GAIN_R: cmd.op = vmix_pkg::OP_GAIN_R;
            vmix_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.op = vmix_pkg::OP_COMMIT;
                end
            end
            default: cmd.op = vmix_pkg::OP_NONE;
        endcase
    end

    // The output request stays until the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == vmix_pkg::OP_COMMIT)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vmix_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == vmix_pkg::OP_COMMIT |-> (!out_valid_reg || !out_stall))
        else $error("result committed over an unread result");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != vmix_pkg::ST_IDLE)
        else $error("accepted request did not start work");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == vmix_pkg::OP_COMMIT |=> out_valid_reg)
        else $error("committed result not presented");
`endif

endmodule

FILE: sv/vmix_datapath.sv
module vmix_datapath
#(
    parameter int FRAC_BITS    = 16,
    parameter int FILTER_SHIFT = 16,
    parameter int RAMP_SHIFT   = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  vmix_pkg::cmd_t      cmd,
    output vmix_pkg::status_t   status,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic signed [15:0]  sample_now,
    input  logic signed [15:0]  sample_next,
    input  logic signed [31:0]  mix_left_in,
    input  logic signed [31:0]  mix_right_in,
    input  logic                single_ramp,
    output logic signed [31:0]  mix_left_out,
    output logic signed [31:0]  mix_right_out,
    output logic [8:0]          advance
);

    localparam int AW = 52;
    localparam int PW = 51;
    localparam int FRAC_MID = ((2 ** FRAC_BITS) - 1) >> 1;
    localparam logic signed [AW-1:0] Y_MIN = AW'(vmix_pkg::FILT_OUT_MIN);
    localparam logic signed [AW-1:0] Y_MAX = AW'(vmix_pkg::FILT_OUT_MAX);

    // Configuration registers
    logic [2:0]         mix_mode_reg;
    logic [23:0]        pitch_step_reg;
    logic [14:0]        volume_left_reg;
    logic [14:0]        volume_right_reg;
    logic signed [31:0] coef_input_reg;
    logic signed [31:0] coef_hist_one_reg;
    logic signed [31:0] coef_hist_two_reg;

    // Voice state
    logic [FRAC_BITS-1:0] frac_reg;
    logic signed [15:0]   ramp_left_reg;
    logic signed [15:0]   ramp_right_reg;
    logic                 phase_reg;
    logic signed [15:0]   hist_one_reg;
    logic signed [15:0]   hist_two_reg;

    // Working registers of one request
    logic signed [15:0]   now_reg;
    logic signed [15:0]   next_reg;
    logic signed [17:0]   smp_reg;
    logic signed [17:0]   smp_next;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [31:0]   left_in_reg;
    logic signed [31:0]   right_in_reg;
    logic                 single_reg;
    logic signed [31:0]   left_out_reg;
    logic signed [31:0]   right_out_reg;
    logic [8:0]           advance_reg;

    logic                 sixteen;
    logic [1:0]           kind;
    logic signed [15:0]   plain_now;
    logic signed [15:0]   wide_now;
    logic signed [15:0]   wide_next;
    logic signed [17:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] sum;
    logic signed [AW-1:0] interp_shifted;
    logic signed [AW-1:0] filt_shifted;
    logic signed [32:0]   gain_left;
    logic signed [32:0]   gain_right;
    logic [24:0]          pos_sum;
    logic [24:0]          whole;
    logic signed [15:0]   ramp_left_new;
    logic signed [15:0]   ramp_right_new;
    logic [3:0]           ramp_sh;

    assign sixteen     = mix_mode_reg[0];
    assign kind        = mix_mode_reg[2:1];
    assign status.kind = kind;

    // Widen the source samples; 8-bit mode repeats the byte below itself, or puts zeros below it for the plain kind.
    assign plain_now = sixteen ? sample_now : $signed({sample_now[7:0], 8'h00});
    assign wide_now  = sixteen ? sample_now : $signed({sample_now[7:0], sample_now[7:0]});
    assign wide_next = sixteen ? sample_next : $signed({sample_next[7:0], sample_next[7:0]});

    assign gain_left  = (kind[1]) ? 33'(ramp_left_reg)  : $signed({18'd0, volume_left_reg});
    assign gain_right = (kind[1]) ? 33'(ramp_right_reg) : $signed({18'd0, volume_right_reg});

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = smp_reg;
        mul_b = gain_left;
        case (cmd.op)
            vmix_pkg::OP_INT0:
            begin
                mul_a = 18'(now_reg);
                mul_b = 33'(FRAC_MID) - 33'(frac_reg[FRAC_BITS-1:1]);
            end
            vmix_pkg::OP_INT1:
            begin
                mul_a = 18'(next_reg);
                mul_b = 33'(frac_reg[FRAC_BITS-1:1]);
            end
            vmix_pkg::OP_FIL0:
            begin
                mul_a = smp_reg;
                mul_b = 33'(coef_input_reg);
            end
            vmix_pkg::OP_FIL1:
            begin
                mul_a = 18'(hist_one_reg);
                mul_b = 33'(coef_hist_one_reg);
            end
            vmix_pkg::OP_FIL2:
            begin
                mul_a = 18'(hist_two_reg);
                mul_b = 33'(coef_hist_two_reg);
            end
            vmix_pkg::OP_GAIN_R:
            begin
                mul_a = smp_reg;
                mul_b = gain_right;
            end
            default:
            begin
                mul_a = smp_reg;
                mul_b = gain_left;
            end
        endcase
    end

    assign prod = PW'(mul_a * mul_b);
    assign sum  = acc_reg + AW'(prod);

    // Interpolation of the filtered kind keeps one fraction bit less.
    assign interp_shifted = (kind == vmix_pkg::KIND_FILTERED) ? (sum >>> FRAC_BITS)
                                                               : (sum >>> (FRAC_BITS - 1));
    assign filt_shifted = sum >>> FILTER_SHIFT;

    // Accumulator and working sample
    always_comb
    begin
        acc_next = acc_reg;
        smp_next = smp_reg;
        case (cmd.op)
            vmix_pkg::OP_LOAD:
            begin
                smp_next = 18'(plain_now);
            end
            vmix_pkg::OP_INT0:
            begin
                acc_next = AW'(prod);
            end
            vmix_pkg::OP_INT1:
            begin
                smp_next = interp_shifted[17:0];
            end
            vmix_pkg::OP_FIL0:
            begin
                acc_next = AW'(prod);
            end
            vmix_pkg::OP_FIL1:
            begin
                acc_next = sum;
            end
            vmix_pkg::OP_FIL2:
            begin
                if (filt_shifted < Y_MIN)
                begin
                    smp_next = 18'(Y_MIN);
                end
                else if (filt_shifted > Y_MAX)
                begin
                    smp_next = 18'(Y_MAX);
                end
                else
                begin
                    smp_next = filt_shifted[17:0];
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Ramp step: a lone step uses the full shift, a paired one a shift less.
    assign ramp_sh = single_reg ? 4'(RAMP_SHIFT) : 4'(RAMP_SHIFT - 1);

    always_comb
    begin
        logic signed [16:0] diff_l;
        logic signed [16:0] diff_r;
        logic signed [16:0] step_l;
        logic signed [16:0] step_r;
        diff_l = $signed({2'b00, volume_left_reg}) - 17'(ramp_left_reg);
        diff_r = $signed({2'b00, volume_right_reg}) - 17'(ramp_right_reg);
        step_l = diff_l >>> ramp_sh;
        step_r = diff_r >>> ramp_sh;
        ramp_left_new  = ramp_left_reg + step_l[15:0];
        ramp_right_new = ramp_right_reg + step_r[15:0];
    end

    // Position advance
    assign pos_sum = 25'(frac_reg) + 25'(pitch_step_reg);
    assign whole   = pos_sum >> FRAC_BITS;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_mode_reg      <= 3'd0;
            pitch_step_reg    <= 24'd65536;
            volume_left_reg   <= 15'd0;
            volume_right_reg  <= 15'd0;
            coef_input_reg    <= 32'sd0;
            coef_hist_one_reg <= 32'sd0;
            coef_hist_two_reg <= 32'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vmix_pkg::CFG_MIX_MODE:      mix_mode_reg      <= cfg_data[2:0];
                vmix_pkg::CFG_PITCH_STEP:    pitch_step_reg    <= cfg_data[23:0];
                vmix_pkg::CFG_VOLUME_LEFT:   volume_left_reg   <= cfg_data[14:0];
                vmix_pkg::CFG_VOLUME_RIGHT:  volume_right_reg  <= cfg_data[14:0];
                vmix_pkg::CFG_COEF_INPUT:    coef_input_reg    <= $signed(cfg_data);
                vmix_pkg::CFG_COEF_HIST_ONE: coef_hist_one_reg <= $signed(cfg_data);
                vmix_pkg::CFG_COEF_HIST_TWO: coef_hist_two_reg <= $signed(cfg_data);
                default:                     mix_mode_reg      <= mix_mode_reg;
            endcase
        end
    end

    // Voice state, updated once the result is committed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg       <= '0;
            ramp_left_reg  <= 16'sd0;
            ramp_right_reg <= 16'sd0;
            phase_reg      <= 1'b0;
            hist_one_reg   <= 16'sd0;
            hist_two_reg   <= 16'sd0;
        end
        else if (cmd.op == vmix_pkg::OP_COMMIT)
        begin
            frac_reg <= pos_sum[FRAC_BITS-1:0];
            if (kind == vmix_pkg::KIND_FILTERED)
            begin
                hist_two_reg <= hist_one_reg;
                hist_one_reg <= smp_reg[15:0];
            end
            if (kind[1])
            begin
                if (single_reg || phase_reg)
                begin
                    ramp_left_reg  <= ramp_left_new;
                    ramp_right_reg <= ramp_right_new;
                    phase_reg      <= 1'b0;
                end
                else
                begin
                    phase_reg <= 1'b1;
                end
            end
        end
    end

    // Working and output registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        smp_reg <= smp_next;
        if (cmd.op == vmix_pkg::OP_LOAD)
        begin
            now_reg      <= wide_now;
            next_reg     <= wide_next;
            left_in_reg  <= mix_left_in;
            right_in_reg <= mix_right_in;
            single_reg   <= single_ramp;
        end
        if (cmd.op == vmix_pkg::OP_GAIN_L)
        begin
            left_in_reg <= left_in_reg + $signed(prod[31:0]);
        end
        if (cmd.op == vmix_pkg::OP_GAIN_R)
        begin
            right_in_reg <= right_in_reg + $signed(prod[31:0]);
        end
        if (cmd.op == vmix_pkg::OP_COMMIT)
        begin
            left_out_reg  <= left_in_reg;
            right_out_reg <= right_in_reg;
            advance_reg   <= (whole > 25'(vmix_pkg::ADVANCE_MAX)) ? vmix_pkg::ADVANCE_MAX
                                                                  : whole[8:0];
        end
    end

    assign mix_left_out  = left_out_reg;
    assign mix_right_out = right_out_reg;
    assign advance       = advance_reg;

endmodule

FILE: sv/voice_mixer_interp_ramp_filter_core.sv
// Single-voice stereo mixer with linear interpolation, volume ramping and a
// two-pole resonant filter.
// Input channel (in_valid / in_stall) carries one request per output frame:
// the current and next source samples, the two accumulator words and the
// single_ramp flag. Output channel (out_valid / out_stall) returns the
// updated accumulators and the whole-sample advance, one result per request.
// The configuration channel (cfg_valid / cfg_ready) writes one register per request;
// cfg_ready is always high. The user must make writes only while idle; the block does not enforce it.
// One shared multiplier does all products in turn. An accepted request passes
// through INT0 and INT1 unless plain, FIL0 to FIL2 with the filter, then GAIN_L,
// GAIN_R and FINISH, where its result is committed and registered to the output.
// No new request is taken until the block is idle again. The next request is
// accepted in the cycle after the result is committed.
// Reset clears the position, ramp volumes, pair phase and filter history,
// and sets the registers to their defaults (pitch step one whole sample).
// A stalled result is held; the block may finish the next request up to
// its commit step, where it waits until the held result is taken.
module voice_mixer_interp_ramp_filter_core
#(
    parameter int FRAC_BITS    = 16,
    parameter int FILTER_SHIFT = 16,
    parameter int RAMP_SHIFT   = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] sample_now,
    input  logic signed [15:0] sample_next,
    input  logic signed [31:0] mix_left_in,
    input  logic signed [31:0] mix_right_in,
    input  logic               single_ramp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] mix_left_out,
    output logic signed [31:0] mix_right_out,
    output logic [8:0]         advance
);

    vmix_pkg::cmd_t    cmd;
    vmix_pkg::status_t status;

    assign cfg_ready = 1'b1;

    vmix_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    vmix_datapath
    #(
        .FRAC_BITS    (FRAC_BITS),
        .FILTER_SHIFT (FILTER_SHIFT),
        .RAMP_SHIFT   (RAMP_SHIFT)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_now    (sample_now),
        .sample_next   (sample_next),
        .mix_left_in   (mix_left_in),
        .mix_right_in  (mix_right_in),
        .single_ramp   (single_ramp),
        .mix_left_out  (mix_left_out),
        .mix_right_out (mix_right_out),
        .advance       (advance)
    );

endmodule

FILE: bench/tb_voice_mixer_interp_ramp_filter_core.sv
`timescale 1ns / 1ps

module tb_voice_mixer_interp_ramp_filter_core;

    localparam int FRAC_BITS    = 16;
    localparam int FILTER_SHIFT = 16;
    localparam int RAMP_SHIFT   = 7;
    localparam longint CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] sample_now;
    logic signed [15:0] sample_next;
    logic signed [31:0] mix_left_in;
    logic signed [31:0] mix_right_in;
    logic               single_ramp;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] mix_left_out;
    logic signed [31:0] mix_right_out;
    logic [8:0]         advance;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic [8:0]  adv;
    } frame_t;

    voice_mixer_interp_ramp_filter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_now    (sample_now),
        .sample_next   (sample_next),
        .mix_left_in   (mix_left_in),
        .mix_right_in  (mix_right_in),
        .single_ramp   (single_ramp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mix_left_out  (mix_left_out),
        .mix_right_out (mix_right_out),
        .advance       (advance)
    );

    // Shadow of the registers and the voice state.
    logic [2:0]  sh_mode;
    logic [23:0] sh_pitch;
    logic [14:0] sh_vol_l, sh_vol_r;
    longint      sh_coef_in, sh_coef_h1, sh_coef_h2;
    logic [15:0] sh_frac;
    longint      sh_ramp_l, sh_ramp_r;
    bit          sh_phase;
    longint      sh_hist1, sh_hist2;

    frame_t expected_frames[$];
    int     mismatch_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off_cycles;
    longint cycle_count;

    function automatic longint widen_sample(logic [15:0] raw, bit sixteen, bit plain);
        longint b;
        if (sixteen)
            return longint'($signed(raw));
        b = longint'($signed(raw[7:0]));
        if (plain)
            return b * 256;
        return b * 256 + longint'(raw[7:0]);
    endfunction

    function automatic longint glide(longint cur, longint target, int s);
        return cur + ((target - cur) >>> s);
    endfunction

    // Works out one frame and steps the shadow state.
    function automatic frame_t mix_frame(logic [15:0] s_now, logic [15:0] s_next,
                                        logic [31:0] acc_l, logic [31:0] acc_r,
                                        bit solo);
        frame_t      r;
        logic [1:0]  kind;
        bit          sixteen;
        longint      smp, s0, s1, m, f, acc, y, gl, gr;
        logic [31:0] p;
        kind = sh_mode[2:1];
        sixteen = sh_mode[0];
        if (kind == vmix_pkg::KIND_PLAIN)
            smp = widen_sample(s_now, sixteen, 1'b1);
        else
        begin
            s0 = widen_sample(s_now, sixteen, 1'b0);
            s1 = widen_sample(s_next, sixteen, 1'b0);
            m = ((64'd1 << FRAC_BITS) - 1) >> 1;
            f = longint'(sh_frac >> 1);
            smp = (s0 * (m - f) + s1 * f)
                >>> ((kind == vmix_pkg::KIND_FILTERED) ? FRAC_BITS : FRAC_BITS - 1);
        end
        if (kind == vmix_pkg::KIND_FILTERED)
        begin
            acc = smp * sh_coef_in + sh_hist1 * sh_coef_h1 + sh_hist2 * sh_coef_h2;
            y = acc >>> FILTER_SHIFT;
            if (y < vmix_pkg::FILT_OUT_MIN) y = vmix_pkg::FILT_OUT_MIN;
            if (y > vmix_pkg::FILT_OUT_MAX) y = vmix_pkg::FILT_OUT_MAX;
            sh_hist2 = sh_hist1;
            sh_hist1 = y;
            smp = y;
        end
        if (kind == vmix_pkg::KIND_RAMPED || kind == vmix_pkg::KIND_FILTERED)
        begin
            gl = sh_ramp_l;
            gr = sh_ramp_r;
        end
        else
        begin
            gl = sh_vol_l;
            gr = sh_vol_r;
        end
        r.left = acc_l + 32'(smp * gl);
        r.right = acc_r + 32'(smp * gr);
        if (kind == vmix_pkg::KIND_RAMPED || kind == vmix_pkg::KIND_FILTERED)
        begin
            if (solo)
            begin
                sh_ramp_l = glide(sh_ramp_l, sh_vol_l, RAMP_SHIFT);
                sh_ramp_r = glide(sh_ramp_r, sh_vol_r, RAMP_SHIFT);
                sh_phase = 0;
            end
            else if (sh_phase)
            begin
                sh_ramp_l = glide(sh_ramp_l, sh_vol_l, RAMP_SHIFT - 1);
                sh_ramp_r = glide(sh_ramp_r, sh_vol_r, RAMP_SHIFT - 1);
                sh_phase = 0;
            end
            else
                sh_phase = 1;
        end
        p = {16'd0, sh_frac} + {8'd0, sh_pitch};
        r.adv = ((p >> FRAC_BITS) > 511) ? vmix_pkg::ADVANCE_MAX : 9'(p >> FRAC_BITS);
        sh_frac = p[15:0];
        return r;
    endfunction

    // Clock and cycle limit.
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb_voice_mixer_interp_ramp_filter_core: FAIL");
                $finish;
            end
        end
    end

    // Receiver stall: random, or a counted hold-off when one is asked for.
    initial
    begin
        out_stall = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker.
    initial
    begin
        frame_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h %h %0d",
                                 mix_left_out, mix_right_out, advance);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (want.left !== mix_left_out || want.right !== mix_right_out
                        || want.adv !== advance)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %h %h %0d, got %h %h %0d",
                                     want.left, want.right, want.adv,
                                     mix_left_out, mix_right_out, advance);
                    end
                end
            end
        end
    end

    // Sends one request and predicts its result on acceptance.
    // Valid is left high after acceptance; drain lowers it, and the next call lowers it only while it idles.
    task automatic send_frame(logic [15:0] s_now, logic [15:0] s_next,
                              logic [31:0] acc_l, logic [31:0] acc_r, bit solo);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_now <= s_now;
        sample_next <= s_next;
        mix_left_in <= acc_l;
        mix_right_in <= acc_r;
        single_ramp <= solo;
        do
            @(posedge clk);
        while (in_stall);
        expected_frames.push_back(mix_frame(s_now, s_next, acc_l, acc_r, solo));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            vmix_pkg::CFG_MIX_MODE:      sh_mode = val[2:0];
            vmix_pkg::CFG_PITCH_STEP:    sh_pitch = val[23:0];
            vmix_pkg::CFG_VOLUME_LEFT:   sh_vol_l = val[14:0];
            vmix_pkg::CFG_VOLUME_RIGHT:  sh_vol_r = val[14:0];
            vmix_pkg::CFG_COEF_INPUT:    sh_coef_in = longint'($signed(val));
            vmix_pkg::CFG_COEF_HIST_ONE: sh_coef_h1 = longint'($signed(val));
            vmix_pkg::CFG_COEF_HIST_TWO: sh_coef_h2 = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic send_random(int count);
        repeat (count)
            send_frame(16'($urandom), 16'($urandom), $urandom, $urandom,
                       ($urandom_range(7) == 0));
    endtask

    // Extremes of samples and accumulators in every mode.
    task automatic test_directed();
        write_reg(vmix_pkg::CFG_VOLUME_LEFT, 32'h7FFF);
        write_reg(vmix_pkg::CFG_VOLUME_RIGHT, 32'h1234);
        write_reg(vmix_pkg::CFG_PITCH_STEP, 32'h00FFFFFF);
        for (int md = 0; md < 8; md++)
        begin
            drain();
            write_reg(vmix_pkg::CFG_MIX_MODE, md);
            send_frame(16'h8000, 16'h7FFF, 32'h7FFFFFFF, 32'h80000000, 1'b0);
            send_frame(16'h7FFF, 16'h8000, 32'h80000000, 32'hFFFFFFFF, 1'b1);
            send_frame(16'h0080, 16'hFF7F, 32'h0, 32'h7FFFFFFF, 1'b0);
        end
        drain();
        write_reg(vmix_pkg::CFG_PITCH_STEP, 32'h0);
        send_frame(16'hFFFF, 16'h0001, 32'h1, 32'h2, 1'b0);
    endtask

    // Random phase over a given setting.
    task automatic test_setting(logic [2:0] md, logic [31:0] pitch, int count);
        drain();
        write_reg(vmix_pkg::CFG_MIX_MODE, md);
        write_reg(vmix_pkg::CFG_PITCH_STEP, pitch);
        write_reg(vmix_pkg::CFG_VOLUME_LEFT, $urandom_range(32767));
        write_reg(vmix_pkg::CFG_VOLUME_RIGHT, $urandom_range(32767));
        // Coefficients mostly near unity keep the filter lively without pinning the clamp; some are fully random.
        write_reg(vmix_pkg::CFG_COEF_INPUT,
                  $urandom_range(1) ? $urandom : 32'($urandom_range(65536)));
        write_reg(vmix_pkg::CFG_COEF_HIST_ONE, 32'($signed($urandom_range(131072)) - 65536));
        write_reg(vmix_pkg::CFG_COEF_HIST_TWO, $urandom_range(3) == 0 ? $urandom
                  : 32'($signed($urandom_range(65536)) - 32768));
        send_random(count);
    endtask

    // Long receiver hold-off while requests keep coming.
    task automatic test_backpressure();
        hold_off_cycles = 200;
        send_random(30);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_now = '0;
        sample_next = '0;
        mix_left_in = '0;
        mix_right_in = '0;
        single_ramp = 1'b0;
        mismatch_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 31;
        recv_idle_pct = 62;
        sh_mode = '0; sh_pitch = 24'h010000; sh_vol_l = '0; sh_vol_r = '0;
        sh_coef_in = 0; sh_coef_h1 = 0; sh_coef_h2 = 0;
        sh_frac = '0; sh_ramp_l = 0; sh_ramp_r = 0; sh_phase = 0;
        sh_hist1 = 0; sh_hist2 = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 62 : 0;
            recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 31 : 0;
            for (int k = 0; k < 8; k++)
                test_setting(3'(k), (k % 3 == 0) ? $urandom_range(24'hFFFFFF)
                             : $urandom_range(24'h030000), 75);
            test_backpressure();
        end
        drain();

        if (mismatch_count == 0 && expected_frames.size() == 0)
            $display("tb_voice_mixer_interp_ramp_filter_core: PASS");
        else
            $display("tb_voice_mixer_interp_ramp_filter_core: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/vmix_pkg.sv
sv/vmix_ctrl.sv
sv/vmix_datapath.sv
sv/voice_mixer_interp_ramp_filter_core.sv
bench/tb_voice_mixer_interp_ramp_filter_core.sv
